### rtl/core/gkw_pkg.sv
// Shared constants, types and tables of the Gaussian kernel weight generator.
`timescale 1ns / 1ps
`default_nettype none

package gkw_pkg;

	// Kernel size
	localparam int MAX_TAPS = 16;
	localparam int IDX_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W    = $clog2(MAX_TAPS + 1);

	// Field widths
	localparam int TAPC_W   = 5;
	localparam int SPREAD_W = 16;
	localparam int TIDX_W   = 4;
	localparam int RAW_W    = 16;
	localparam int TOTAL_W  = 22;
	localparam int SUM_W    = $clog2(MAX_TAPS * 32768 + 1);
	localparam logic [RAW_W-1:0] RAW_ONE = 16'h8000;

	// Exponential datapath, UQ1.30
	localparam int Q_W       = 30;
	localparam int X_W       = 30;
	localparam int P_W       = 31;
	localparam int EXP_TERMS = 12;
	localparam int K_W       = 4;
	localparam int SQ_STEPS  = 4;
	localparam int SQ_W      = 2;
	localparam int RND_SH    = 15;

	// Shared multiplier
	localparam int MA_W     = 31;
	localparam int MB_W     = 34;
	localparam int PROD_W   = MA_W + MB_W;
	localparam int RECIP_SH = 34;

	// Shared serial divider
	localparam int REM_W   = 22;
	localparam int NUM_W   = 31;
	localparam int STEP_W  = 5;
	localparam int X_STEPS = 30;
	localparam int N_STEPS = 31;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TAP_START,
		ST_X_DIV,
		ST_TERM_MUL1,
		ST_TERM_MUL2,
		ST_TERM_UPD,
		ST_SQ_MUL,
		ST_SQ_UPD,
		ST_TAP_ROUND,
		ST_TAP_STORE,
		ST_TOTAL,
		ST_NORM_RD,
		ST_NORM_START,
		ST_NORM_DIV
	} gkw_state_t;

	// Divider request and response
	typedef struct packed {
		logic              start;
		logic [REM_W-1:0]  rem_init;
		logic [NUM_W-1:0]  numer;
		logic [REM_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} gkw_div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} gkw_div_rsp_t;

	// ceil(2^34 / k): floor(v / k) == (v * m) >> 34 for v < 2^30, k in 2..12
	function automatic logic [MB_W-1:0] recip_k(input logic [K_W-1:0] k);
		logic [MB_W-1:0] m;
		unique case (k)
			4'd2:    m = 34'd8589934592;
			4'd3:    m = 34'd5726623062;
			4'd4:    m = 34'd4294967296;
			4'd5:    m = 34'd3435973837;
			4'd6:    m = 34'd2863311531;
			4'd7:    m = 34'd2454267027;
			4'd8:    m = 34'd2147483648;
			4'd9:    m = 34'd1908874354;
			4'd10:   m = 34'd1717986919;
			4'd11:   m = 34'd1561806290;
			4'd12:   m = 34'd1431655766;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

### rtl/core/gkw_mul.sv
// Shared multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module gkw_mul (
	input  wire logic                       clk,
	input  wire logic [gkw_pkg::MA_W-1:0]   a,
	input  wire logic [gkw_pkg::MB_W-1:0]   b,
	output logic      [gkw_pkg::PROD_W-1:0] prod_q
);
	import gkw_pkg::*;

	// one product per cycle, product registered
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

### rtl/core/gkw_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gkw_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gkw_pkg::gkw_div_req_t req,
	output gkw_pkg::gkw_div_rsp_t      rsp
);
	import gkw_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  div_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quot_q;
	logic [REM_W:0]    rem_sh;
	logic [REM_W:0]    rem_sub;
	logic              ge;

	// shift in next numerator bit and trial-subtract
	always_comb begin
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, div_q};
		ge      = (rem_sh >= {1'b0, div_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// done follows the final quotient bit
			done_q <= !req.start && run_q && (cnt_q == STEP_W'(1));
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			div_q  <= req.divisor;
			num_q  <= req.numer;
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

### rtl/core/gaussian_kernel_weight_generator.sv
// Top level: sequencer, raw weight store and result registers of the kernel generator.
//
// A request (tap_count, spread) is taken when start is high and busy is low; busy then
// stays high until the run is over. For every tap distance i the block forms
// x = (i*i << 33) / spread on the shared bit-serial divider, forms exp(-16x) as a
// 12-term Horner chain for exp(-x) and four squarings on the shared multiplier, and
// stores the raw UQ1.15 weight. It then divides each raw weight by the two-sided total
// on the same divider and presents one result per tap on tap_index, weight and last
// for a single cycle, marked by valid; the receiver must take each result in that
// cycle. The center tap and taps whose weight underflows skip the exponential.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_kernel_weight_generator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [gkw_pkg::TAPC_W-1:0]   tap_count,
	input  wire logic [gkw_pkg::SPREAD_W-1:0] spread,
	output logic                              busy,
	output logic                              valid,
	output logic      [gkw_pkg::TIDX_W-1:0]   tap_index,
	output logic      [gkw_pkg::RAW_W-1:0]    weight,
	output logic                              last
);
	import gkw_pkg::*;

	localparam logic [P_W-1:0]    Q_ONE   = P_W'(1) << Q_W;
	localparam logic [P_W-1:0]    RND_ADD = P_W'(1) << (RND_SH - 1);
	localparam logic [PROD_W-1:0] SQ_ADD  = PROD_W'(1) << (Q_W - 1);

	gkw_state_t state_q, state_d;

	logic [CNT_W-1:0]    n_q;
	logic [IDX_W-1:0]    i_q;
	logic [SPREAD_W-1:0] spread_q;
	logic [X_W-1:0]      x_q;
	logic [P_W-1:0]      p_q;
	logic [K_W-1:0]      k_q;
	logic [SQ_W-1:0]     sq_q;
	logic [RAW_W-1:0]    raw_q;
	logic [RAW_W-1:0]    rd_q;
	logic [SUM_W-1:0]    sum_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                valid_q;
	logic [TIDX_W-1:0]   tap_index_q;
	logic [RAW_W-1:0]    weight_q;
	logic                last_q;

	logic [RAW_W-1:0]    raw_mem [MAX_TAPS];

	logic [MA_W-1:0]     mul_a;
	logic [MB_W-1:0]     mul_b;
	logic [PROD_W-1:0]   prod_q;
	logic [PROD_W-1:0]   prod_rnd;
	logic [X_W-1:0]      term_v;
	logic [X_W-1:0]      term_div;
	logic [P_W-1:0]      p_rnd;
	logic [REM_W-1:0]    i_sq8;
	logic                tap_zero;
	logic                last_tap;
	logic                accept;
	logic [SUM_W:0]      sum_dbl;
	gkw_div_req_t        div_req;
	gkw_div_rsp_t        div_rsp;

	// shared units
	gkw_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	gkw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// decode helpers
	always_comb begin
		accept   = start && (state_q == ST_IDLE);
		i_sq8    = (REM_W'(i_q) * REM_W'(i_q)) << 3;
		tap_zero = (i_sq8 >= REM_W'(spread_q));
		last_tap = (CNT_W'(i_q) == (n_q - CNT_W'(1)));
		term_v   = prod_q[Q_W +: X_W];
		term_div = prod_q[RECIP_SH +: X_W];
		prod_rnd = prod_q + SQ_ADD;
		p_rnd    = p_q + RND_ADD;
		sum_dbl  = {sum_q, 1'b0} - (SUM_W + 1)'(RAW_ONE);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (accept) state_d = ST_TAP_START;
			ST_TAP_START: begin
				if (i_q == '0 || tap_zero) state_d = ST_TAP_STORE;
				else state_d = ST_X_DIV;
			end
			ST_X_DIV:      if (div_rsp.done) state_d = ST_TERM_MUL1;
			ST_TERM_MUL1:  state_d = ST_TERM_MUL2;
			ST_TERM_MUL2: begin
				if (k_q == K_W'(1)) state_d = ST_SQ_MUL;
				else state_d = ST_TERM_UPD;
			end
			ST_TERM_UPD:   state_d = ST_TERM_MUL1;
			ST_SQ_MUL:     state_d = ST_SQ_UPD;
			ST_SQ_UPD: begin
				if (sq_q == SQ_W'(SQ_STEPS - 1)) state_d = ST_TAP_ROUND;
				else state_d = ST_SQ_MUL;
			end
			ST_TAP_ROUND:  state_d = ST_TAP_STORE;
			ST_TAP_STORE: begin
				if (last_tap) state_d = ST_TOTAL;
				else state_d = ST_TAP_START;
			end
			ST_TOTAL:      state_d = ST_NORM_RD;
			ST_NORM_RD:    state_d = ST_NORM_START;
			ST_NORM_START: state_d = ST_NORM_DIV;
			ST_NORM_DIV: begin
				if (div_rsp.done) state_d = last_tap ? ST_IDLE : ST_NORM_RD;
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// unit operands and divider requests
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		div_req = '0;
		unique case (state_q)
			ST_TAP_START: begin
				div_req.start    = (i_q != '0) && !tap_zero;
				div_req.rem_init = i_sq8;
				div_req.divisor  = REM_W'(spread_q);
				div_req.steps    = STEP_W'(X_STEPS);
			end
			ST_TERM_MUL1: begin
				mul_a = MA_W'(p_q);
				mul_b = MB_W'(x_q);
			end
			ST_TERM_MUL2: begin
				mul_a = MA_W'(term_v);
				mul_b = recip_k(k_q);
			end
			ST_SQ_MUL: begin
				mul_a = MA_W'(p_q);
				mul_b = MB_W'(p_q);
			end
			ST_NORM_START: begin
				div_req.start   = 1'b1;
				div_req.numer   = (NUM_W'(rd_q) << RND_SH) + NUM_W'(total_q >> 1);
				div_req.divisor = REM_W'(total_q);
				div_req.steps   = STEP_W'(N_STEPS);
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				div_req = '0;
			end
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			i_q     <= '0;
			n_q     <= '0;
			sum_q   <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			// strobe for one cycle per finished normalization division
			valid_q <= (state_q == ST_NORM_DIV) && div_rsp.done;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q   <= '0;
						sum_q <= '0;
						if (tap_count == '0) n_q <= CNT_W'(1);
						else if (32'(tap_count) > MAX_TAPS) n_q <= CNT_W'(MAX_TAPS);
						else n_q <= CNT_W'(tap_count);
					end
				end
				ST_TAP_STORE: begin
					sum_q <= sum_q + SUM_W'(raw_q);
					if (!last_tap) i_q <= i_q + IDX_W'(1);
				end
				ST_TOTAL: begin
					total_q <= TOTAL_W'(sum_dbl);
					i_q     <= '0;
				end
				ST_NORM_DIV: begin
					if (div_rsp.done && !last_tap) i_q <= i_q + IDX_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// exponential datapath and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) spread_q <= spread;
			end
			ST_TAP_START: begin
				raw_q <= (i_q == '0) ? RAW_ONE : '0;
			end
			ST_X_DIV: begin
				if (div_rsp.done) begin
					x_q <= div_rsp.quot[X_W-1:0];
					p_q <= Q_ONE;
					k_q <= K_W'(EXP_TERMS);
				end
			end
			ST_TERM_MUL2: begin
				// divide by one needs no reciprocal
				if (k_q == K_W'(1)) begin
					p_q  <= Q_ONE - P_W'(term_v);
					sq_q <= '0;
				end
			end
			ST_TERM_UPD: begin
				p_q <= Q_ONE - P_W'(term_div);
				k_q <= k_q - K_W'(1);
			end
			ST_SQ_UPD: begin
				p_q  <= prod_rnd[Q_W +: P_W];
				sq_q <= sq_q + SQ_W'(1);
			end
			ST_TAP_ROUND: begin
				raw_q <= p_rnd[P_W-1 -: RAW_W];
			end
			ST_NORM_DIV: begin
				if (div_rsp.done) begin
					tap_index_q <= TIDX_W'(i_q);
					weight_q    <= (total_q == '0) ? '0 : div_rsp.quot[RAW_W-1:0];
					last_q      <= last_tap;
				end
			end
			default: begin
			end
		endcase
	end

	// raw weight store
	always_ff @(posedge clk) begin
		if (state_q == ST_TAP_STORE) raw_mem[i_q] <= raw_q;
		rd_q <= raw_mem[i_q];
	end

	assign busy      = (state_q != ST_IDLE);
	assign valid     = valid_q;
	assign tap_index = tap_index_q;
	assign weight    = weight_q;
	assign last      = last_q;

endmodule

`default_nettype wire

### rtl/core/gkw_checker.sv
// Port-level assertions for the kernel generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gkw_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         valid,
	input wire logic [gkw_pkg::TIDX_W-1:0]   tap_index,
	input wire logic [gkw_pkg::RAW_W-1:0]    weight,
	input wire logic                         last
);
	import gkw_pkg::*;

	// an accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request accepted");

	// results other than the final one appear only inside a run
	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("non-final result while idle");

	// the result strobe is never high in consecutive cycles
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("result strobe held for two cycles");

	// normalized weights never exceed one
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (weight <= RAW_ONE))
		else $error("weight above unity");

	// the center tap always carries a nonzero weight
	a_center_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && tap_index == '0) |-> (weight != '0))
		else $error("center tap weight is zero");

endmodule

bind gaussian_kernel_weight_generator gkw_checker u_gkw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.valid     (valid),
	.tap_index (tap_index),
	.weight    (weight),
	.last      (last)
);

`default_nettype wire
